@@ rtl/lzbe_pkg.sv @@
// Shared constants, types and dictionary port bundles of the LZ78 byte encoder.
`default_nettype none

package lzbe_pkg;

  // Dictionary size in phrases; phrase 0 is the empty root phrase.
  localparam int unsigned DictEntries = 4096;
  localparam int unsigned IdxW        = $clog2(DictEntries);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned PhraseW     = 12;
  localparam int unsigned SymW        = 8;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [SymW-1:0] sym_t;

  // One dictionary entry: next sibling under the same prefix, and its byte.
  typedef struct packed {
    idx_t sib;
    sym_t sym;
  } entry_t;

  // Requests from the controller to the dictionary memories.
  typedef struct packed {
    logic   head_rd;
    idx_t   head_rd_addr;
    logic   head_wr;
    idx_t   head_wr_addr;
    idx_t   head_wr_data;
    logic   ent_rd;
    idx_t   ent_rd_addr;
    logic   ent_wr;
    idx_t   ent_wr_addr;
    entry_t ent_wr_data;
  } dict_req_t;

  // Registered read data, valid the cycle after the read.
  typedef struct packed {
    idx_t   head;
    entry_t ent;
  } dict_rsp_t;

endpackage

`default_nettype wire

@@ rtl/lzbe_if.sv @@
// Valid/ready channel interfaces for input bytes and output codewords.
`default_nettype none

interface lzbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzbe_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] prefix_phrase;
  logic        has_byte;
  logic [7:0]  next_symbol;
  logic        stream_end;

  modport source (output valid, output prefix_phrase, output has_byte,
                  output next_symbol, output stream_end, input ready);
  modport sink   (input valid, input prefix_phrase, input has_byte,
                  input next_symbol, input stream_end, output ready);
endinterface

`default_nettype wire

@@ rtl/lzbe_dict.sv @@
// Dictionary storage: first-child memory and entry (sibling, byte) memory.
`default_nettype none

module lzbe_dict (
  input  wire logic              clk_i,
  input  wire lzbe_pkg::dict_req_t req_i,
  output lzbe_pkg::dict_rsp_t      rsp_o
);

  lzbe_pkg::idx_t   head_mem [lzbe_pkg::DictEntries];
  lzbe_pkg::entry_t ent_mem  [lzbe_pkg::DictEntries];

  lzbe_pkg::idx_t   head_rdata_q;
  lzbe_pkg::entry_t ent_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.head_wr) begin
      head_mem[req_i.head_wr_addr] <= req_i.head_wr_data;
    end
    if (req_i.head_rd) begin
      head_rdata_q <= head_mem[req_i.head_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ent_wr) begin
      ent_mem[req_i.ent_wr_addr] <= req_i.ent_wr_data;
    end
    if (req_i.ent_rd) begin
      ent_rdata_q <= ent_mem[req_i.ent_rd_addr];
    end
  end

  assign rsp_o.head = head_rdata_q;
  assign rsp_o.ent  = ent_rdata_q;

endmodule

`default_nettype wire

@@ rtl/lz78_byte_encoder.sv @@
// LZ78 byte encoder top level: probe sequencer, dictionary and codeword register.
// Sequence: a byte holds the sequencer for an accept step, a first-child read (non-root match),
//   a compare per sibling; a miss or last byte adds an emit, a new non-root child a link write.
// Throughput: one byte at a time; the sibling walk over the entry memory read port sets
//   the pace; emit waits while the codeword register holds an unaccepted beat.
// Reset: asynchronous, active low; empties the dictionary, returns the match to the root
//   and drops any pending codeword. No clearing pass: memories need no initialisation.
`default_nettype none

module lz78_byte_encoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lzbe_in_if.sink    in_i,
  lzbe_out_if.source out_o
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a byte beat
  localparam logic [2:0] ST_HEAD = 3'd1;  // first-child read of the match node returns
  localparam logic [2:0] ST_CMP  = 3'd2;  // entry read returns; compare its byte
  localparam logic [2:0] ST_EMIT = 3'd3;  // load the codeword, add the entry
  localparam logic [2:0] ST_LINK = 3'd4;  // hook the new entry under a non-root node

  localparam lzbe_pkg::cnt_t DictFull = lzbe_pkg::CntW'(lzbe_pkg::DictEntries);
  localparam lzbe_pkg::cnt_t FirstIdx = lzbe_pkg::CntW'(1);

  // Control state
  logic [2:0]      state_q, state_d;
  lzbe_pkg::idx_t  match_q, match_d;      // current match node, 0 = root
  lzbe_pkg::cnt_t  free_q, free_d;        // next phrase number to assign
  lzbe_pkg::idx_t  root_head_q, root_head_d; // first child of the root
  logic            hit_q, hit_d;          // last byte extended the match
  logic            out_valid_q, out_valid_d;

  // Per-byte working registers
  lzbe_pkg::sym_t  sym_q, sym_d;
  logic            last_q, last_d;
  lzbe_pkg::idx_t  ptr_q, ptr_d;          // entry under comparison
  lzbe_pkg::idx_t  head_q, head_d;        // first child of the match node

  // Codeword register
  logic [lzbe_pkg::PhraseW-1:0] out_phrase_q, out_phrase_d;
  logic                         out_has_q, out_has_d;
  lzbe_pkg::sym_t               out_sym_q, out_sym_d;
  logic                         out_end_q, out_end_d;

  lzbe_pkg::dict_req_t dict_req;
  lzbe_pkg::dict_rsp_t dict_rsp;

  logic           out_free;
  logic           probe_en;
  lzbe_pkg::idx_t cand;
  lzbe_pkg::idx_t free_idx;

  lzbe_dict u_dict (
    .clk_i (clk_i),
    .req_i (dict_req),
    .rsp_o (dict_rsp)
  );

  // The codeword slot can take a new beat when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_o.ready;
  assign free_idx = free_q[lzbe_pkg::IdxW-1:0];

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    match_d      = match_q;
    free_d       = free_q;
    root_head_d  = root_head_q;
    hit_d        = hit_q;
    sym_d        = sym_q;
    last_d       = last_q;
    ptr_d        = ptr_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_phrase_d = out_phrase_q;
    out_has_d    = out_has_q;
    out_sym_d    = out_sym_q;
    out_end_d    = out_end_q;
    probe_en     = 1'b0;
    cand         = '0;
    dict_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sym_d  = in_i.data_byte;
          last_d = in_i.last_byte;
          hit_d  = 1'b0;
          if (match_q == '0) begin
            // Root children sit in a register: start the sibling walk at once.
            head_d   = root_head_q;
            cand     = root_head_q;
            probe_en = 1'b1;
          end else begin
            dict_req.head_rd      = 1'b1;
            dict_req.head_rd_addr = match_q;
            state_d               = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        head_d   = dict_rsp.head;
        cand     = dict_rsp.head;
        probe_en = 1'b1;
      end

      ST_CMP: begin
        if (dict_rsp.ent.sym == sym_q) begin
          // Match moves on; only the last byte of a stream emits anything.
          match_d = ptr_q;
          if (last_q) begin
            hit_d   = 1'b1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cand     = dict_rsp.ent.sib;
          probe_en = 1'b1;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_phrase_d = lzbe_pkg::PhraseW'(match_q);
          out_has_d    = !hit_q;
          out_sym_d    = hit_q ? '0 : sym_q;
          out_end_d    = last_q;
          state_d      = ST_IDLE;
          if (hit_q) begin
            // Terminal codeword: stream over, empty the dictionary.
            match_d     = '0;
            free_d      = FirstIdx;
            root_head_d = '0;
          end else if (free_q != DictFull) begin
            // New entry goes to the head of its prefix's child list.
            dict_req.ent_wr           = 1'b1;
            dict_req.ent_wr_addr      = free_idx;
            dict_req.ent_wr_data.sib  = head_q;
            dict_req.ent_wr_data.sym  = sym_q;
            dict_req.head_wr          = 1'b1;
            dict_req.head_wr_addr     = free_idx;
            dict_req.head_wr_data     = '0;
            if (match_q == '0) begin
              root_head_d = free_idx;
              free_d      = free_q + FirstIdx;
              match_d     = '0;
              if (last_q) begin
                free_d      = FirstIdx;
                root_head_d = '0;
              end
            end else begin
              state_d = ST_LINK;
            end
          end else begin
            // Dictionary full: emit only.
            match_d = '0;
            if (last_q) begin
              free_d      = FirstIdx;
              root_head_d = '0;
            end
          end
        end
      end

      ST_LINK: begin
        dict_req.head_wr      = 1'b1;
        dict_req.head_wr_addr = match_q;
        dict_req.head_wr_data = free_idx;
        free_d                = free_q + FirstIdx;
        match_d               = '0;
        state_d               = ST_IDLE;
        if (last_q) begin
          free_d      = FirstIdx;
          root_head_d = '0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Sibling walk: a null pointer ends the list with a miss, else read the entry.
    if (probe_en) begin
      if (cand == '0) begin
        state_d = ST_EMIT;
      end else begin
        dict_req.ent_rd      = 1'b1;
        dict_req.ent_rd_addr = cand;
        ptr_d                = cand;
        state_d              = ST_CMP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      match_q     <= '0;
      free_q      <= FirstIdx;
      root_head_q <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      match_q     <= match_d;
      free_q      <= free_d;
      root_head_q <= root_head_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    last_q       <= last_d;
    ptr_q        <= ptr_d;
    head_q       <= head_d;
    out_phrase_q <= out_phrase_d;
    out_has_q    <= out_has_d;
    out_sym_q    <= out_sym_d;
    out_end_q    <= out_end_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.prefix_phrase = out_phrase_q;
  assign out_o.has_byte      = out_has_q;
  assign out_o.next_symbol   = out_sym_q;
  assign out_o.stream_end    = out_end_q;

endmodule

`default_nettype wire

@@ dv/lzbe_codeword_checker.sv @@
// Codeword checker: watches both channels, predicts every codeword and compares it.
`timescale 1ns / 1ps

module lzbe_codeword_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  lzbe_in_if                byte_i,
  lzbe_out_if               code_i,
  output int unsigned       fault_cnt_o,
  output int unsigned       pending_o
);

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [lzbe_pkg::PhraseW-1:0] phrase;
    logic                         has_sym;
    logic [lzbe_pkg::SymW-1:0]    sym;
    logic                         stream_end;
  } codeword_t;

  // Phrase tree: key is {parent phrase, byte}, value is the child phrase.
  lzbe_pkg::idx_t phrase_child [int];
  lzbe_pkg::cnt_t free_idx;
  lzbe_pkg::idx_t cur_node;
  codeword_t      codeword_q [$];
  int unsigned    fault_cnt;
  int unsigned    pending;
  int unsigned    cw_num;

  assign fault_cnt_o = fault_cnt;
  assign pending_o   = pending;

  function automatic string fmt_cw(input codeword_t c);
    return $sformatf("phrase=%0d has_byte=%0b sym=%02h end=%0b",
                     c.phrase, c.has_sym, c.sym, c.stream_end);
  endfunction

  task automatic flag_fault(input string msg);
    if (fault_cnt < ReportMax) $display("%s", msg);
    fault_cnt++;
  endtask

  task automatic restart_stream();
    phrase_child.delete();
    free_idx = 1;
    cur_node = '0;
  endtask

  // Walk the tree one byte; queue the codeword it emits, if any.
  task automatic predict_codeword(input lzbe_pkg::sym_t sym, input logic is_last);
    int        key;
    codeword_t cw;
    key = int'({cur_node, sym});
    if (phrase_child.exists(key)) begin
      cur_node = phrase_child[key];
      if (is_last) begin
        cw = '{phrase: cur_node, has_sym: 1'b0, sym: '0, stream_end: 1'b1};
        codeword_q = {codeword_q, cw};
        restart_stream();
      end
    end else begin
      cw = '{phrase: cur_node, has_sym: 1'b1, sym: sym, stream_end: is_last};
      codeword_q = {codeword_q, cw};
      // Full dictionary: emit, but add nothing
      if (free_idx < lzbe_pkg::DictEntries) begin
        phrase_child[key] = lzbe_pkg::idx_t'(free_idx);
        free_idx++;
      end
      cur_node = '0;
      if (is_last) restart_stream();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    codeword_t got, want;
    string     bad;
    if (!rst_ni) begin
      restart_stream();
      codeword_q.delete();
      fault_cnt = 0;
      cw_num    = 0;
      pending  <= 0;
    end else begin
      // A codeword can never leave in the cycle its byte arrives: check outputs first
      if (code_i.valid && code_i.ready) begin
        got = '{phrase: code_i.prefix_phrase, has_sym: code_i.has_byte,
                sym: code_i.next_symbol, stream_end: code_i.stream_end};
        if (codeword_q.size() == 0) begin
          flag_fault($sformatf("codeword %0d unexpected: %s", cw_num, fmt_cw(got)));
        end else begin
          want = codeword_q.pop_front();
          bad  = "";
          if (got.phrase !== want.phrase)         bad = {bad, " prefix_phrase"};
          if (got.has_sym !== want.has_sym)       bad = {bad, " has_byte"};
          if (got.sym !== want.sym)               bad = {bad, " next_symbol"};
          if (got.stream_end !== want.stream_end) bad = {bad, " stream_end"};
          if (bad != "") begin
            flag_fault($sformatf("codeword %0d mismatch in%s: expected %s, got %s",
                                 cw_num, bad, fmt_cw(want), fmt_cw(got)));
          end
        end
        cw_num++;
      end
      if (byte_i.valid && byte_i.ready) begin
        predict_codeword(byte_i.data_byte, byte_i.last_byte);
      end
      pending <= codeword_q.size();
    end
  end

endmodule

@@ dv/tb_lz78_byte_encoder.sv @@
// Testbench top for the LZ78 byte encoder: clock, reset, byte stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_lz78_byte_encoder;

  // Random part size, in bytes, and the receiver's one long hold-off, in cycles
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned LongHold   = 400;
  // The slowest byte walks a long sibling list; allow for the long hold on top
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lzbe_in_if  in_w ();
  lzbe_out_if out_w ();

  int unsigned fault_cnt;
  int unsigned pending_cnt;

  // Set by the stimulus once the random part is under way; the receiver acts on it once
  logic        long_hold_armed = 1'b0;
  logic        long_hold_done  = 1'b0;

  // Bytes of the stream being built, and beats left in the sender's current burst
  logic [7:0]  stream_q [$];
  int unsigned burst_left = 0;

  lz78_byte_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  lzbe_codeword_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (in_w),
    .code_i      (out_w),
    .fault_cnt_o (fault_cnt),
    .pending_o   (pending_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one byte and hold it until the beat goes through. Between bursts drop
  // valid for a random gap; the gap is never zero, so valid is not lowered and
  // raised within one time step.
  task automatic push_byte(input logic [7:0] data, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = $urandom_range(1, 10);
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.data_byte <= data;
    in_w.last_byte <= is_last;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // Send the queued bytes as one stream; flag the final byte as last.
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      push_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  // Stop offering and wait until every predicted codeword has come out. The
  // first edge lets the checker take in a beat accepted at this very edge.
  task automatic wait_drained();
    in_w.valid <= 1'b0;
    burst_left  = 0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  alpha [6];
    int unsigned kind, len, asz, mlen, stream_cnt, rand_items;

    in_w.valid     <= 1'b0;
    in_w.data_byte <= '0;
    in_w.last_byte <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed streams. Single-byte streams at both ends of the byte range:
    // no match, so the normal codeword carries the end flag.
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'hFF};
    send_stream();
    // Last byte extends a match: terminal codeword for phrase 1, no byte
    stream_q = '{8'h41, 8'h41};
    send_stream();
    // Match on phrase 1, then a miss on the last byte: (1, 0x42) with the end flag
    stream_q = '{8'h41, 8'h42, 8'h41, 8'h42};
    send_stream();
    // Two-deep match ending the stream: terminal codeword for phrase 2
    stream_q = '{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA};
    send_stream();
    // Complementary bit patterns, with a terminal on the last byte
    stream_q = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80};
    send_stream();

    // Random streams. Mostly small alphabets and repeated motifs, which build
    // deep phrases; the rest is full-range noise and single-byte streams.
    stream_cnt = 0;
    rand_items = 0;
    while (rand_items < RandItems) begin
      stream_q.delete();
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        asz = $urandom_range(2, 6);
        for (int i = 0; i < asz; i++) alpha[i] = 8'($urandom_range(0, 255));
        len = $urandom_range(1, 80);
        repeat (len) stream_q = {stream_q, alpha[$urandom_range(0, asz - 1)]};
      end else if (kind < 15) begin
        mlen = $urandom_range(1, 4);
        for (int i = 0; i < mlen; i++) alpha[i] = 8'($urandom_range(0, 255));
        len = $urandom_range(10, 120);
        for (int i = 0; i < len; i++) stream_q = {stream_q, alpha[i % mlen]};
      end else if (kind < 19) begin
        len = $urandom_range(1, 30);
        repeat (len) stream_q = {stream_q, 8'($urandom_range(0, 255))};
      end else begin
        stream_q = {stream_q, 8'($urandom_range(0, 255))};
      end
      // Pause the sender until the block has drained, once for sure, then now and again
      if (stream_cnt == 3 || $urandom_range(0, 24) == 0) wait_drained();
      // Arm the receiver's long hold-off while the sender keeps streaming
      if (stream_cnt == 8) long_hold_armed = 1'b1;
      send_stream();
      rand_items += stream_q.size();
      stream_cnt++;
    end

    // Every stream ended on a last byte: drain, then let the block settle
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fault_cnt == 0 && pending_cnt == 0) begin
      $display("** lz78_byte_encoder: PASSED **");
    end else begin
      $display("** lz78_byte_encoder: FAILED **");
    end
    $finish;
  end

  // Receiver: segments of steady ready, random stalls and solid stalls, plus one
  // long hold-off so the block fills up and pushes back on its input.
  initial begin : receiver
    int unsigned mode, n;
    out_w.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 9);
      if (long_hold_armed && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_w.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (mode < 3) begin
        n = $urandom_range(20, 120);
        out_w.ready <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else if (mode < 8) begin
        n = $urandom_range(10, 60);
        repeat (n) begin
          out_w.ready <= ($urandom_range(0, 3) != 0);
          @(posedge clk_i);
        end
      end else begin
        n = $urandom_range(1, 20);
        out_w.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles", QuietLimit);
    $display("** lz78_byte_encoder: FAILED **");
    $finish;
  end

endmodule
